// ===== hdl/slwm_pkg.sv =====
// Package for the slow access window monitor.
// Holds sizes, register indexes, method codes and the entry store write request type.
// No dependencies.
`default_nettype none

package slwm_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  localparam int TICK_W = 48;
  localparam int WORD_W = 32;
  localparam int END_W = TICK_W + 1;
  localparam int TOTAL_W = 37;
  localparam int COUNT_OUT_W = 6;
  localparam int ACC_W = WORD_W + CNT_W;
  localparam int REG_IDX_W = 2;
  localparam int METHOD_W = 2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_CHECK_METHOD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_PERIOD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_THRESHOLD = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SLOW_LIMIT = 2'd3;

  // check methods
  localparam logic [METHOD_W-1:0] METHOD_SUM = 2'd0;
  localparam logic [METHOD_W-1:0] METHOD_COUNT = 2'd1;
  localparam logic [METHOD_W-1:0] METHOD_EXCESS = 2'd2;
  localparam logic [METHOD_W-1:0] METHOD_NONE = 2'd3;

  // reset values
  localparam logic [METHOD_W-1:0] METHOD_RESET = METHOD_SUM;
  localparam logic [WORD_W-1:0] WINDOW_RESET = 32'd60000;
  localparam logic [WORD_W-1:0] THRESHOLD_RESET = 32'd1000;
  localparam logic [WORD_W-1:0] LIMIT_RESET = 32'd20000;

  typedef struct packed {
    logic en;
    logic [IDX_W-1:0] addr;
    logic [TICK_W-1:0] start_tick;
    logic [WORD_W-1:0] length;
  } store_wr_t;

endpackage

`default_nettype wire

// ===== hdl/slwm_store.sv =====
// Entry store: start tick and length of each slow access, one write and one read port.
// Depends on slwm_pkg. Read data is registered and appears in the cycle after the address.
`default_nettype none

module slwm_store
  import slwm_pkg::*;
(
  input  wire logic              clk,
  input  wire store_wr_t         wr,
  input  wire logic [IDX_W-1:0]  rd_addr,
  output logic      [TICK_W-1:0] rd_start,
  output logic      [WORD_W-1:0] rd_length
);

  logic [TICK_W-1:0] mem_start [MAX_ENTRIES];
  logic [WORD_W-1:0] mem_length [MAX_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_start[wr.addr] <= wr.start_tick;
      mem_length[wr.addr] <= wr.length;
    end
    rd_start <= mem_start[rd_addr];
    rd_length <= mem_length[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/slow_access_window_monitor_top.sv =====
// Top level of the slow access window monitor: configuration, scan sequencer, result.
// Depends on slwm_pkg and slwm_store.
`default_nettype none

// How to use the block
//   Request channel: drive start_tick and duration and raise start; the request is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with recorded, disk_slow,
//   entry_count, window_total and overflow; the receiver cannot stall it, so sample it.
//   Configuration: wr_en, wr_index and wr_data write one register per edge, with no wait.
//   Write only while busy is low and no result is pending.
// Timing
//   A fast request (duration below slow_threshold) gives its result in the cycle after it
//   is taken, and busy stays low.
//   A slow request holds busy while the states PREP (to form the expiry bound) and SCAN
//   (one pass over the 32 stored entries through the store's single read port, one read
//   per entry into a two stage pipeline) run, then FIX, ADD and DONE (fix-up, store,
//   result). done follows in the next cycle, where a new request may already be taken;
//   a slow request is never overlapped, and the store's read port sets its pace.
// Reset
//   rst (synchronous, active high) empties the window, restores the register defaults
//   and drops any request in flight; no result follows it.

module slow_access_window_monitor_top
  import slwm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  // request
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [TICK_W-1:0]      start_tick,
  input  wire logic [WORD_W-1:0]      duration,
  // configuration
  input  wire logic                   wr_en,
  input  wire logic [REG_IDX_W-1:0]   wr_index,
  input  wire logic [WORD_W-1:0]      wr_data,
  // result
  output logic                        done,
  output logic                        recorded,
  output logic                        disk_slow,
  output logic [COUNT_OUT_W-1:0]      entry_count,
  output logic [TOTAL_W-1:0]          window_total,
  output logic                        overflow
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_ADD  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0] state;

  // configuration registers
  logic [METHOD_W-1:0] check_method;
  logic [WORD_W-1:0] window_period;
  logic [WORD_W-1:0] slow_threshold;
  logic [WORD_W-1:0] slow_limit;

  // window state
  logic [MAX_ENTRIES-1:0] valid;
  logic [CNT_W-1:0] live_count;

  // current request
  logic [TICK_W-1:0] it_start;
  logic [WORD_W-1:0] it_dur;
  logic [END_W-1:0] now;
  logic [END_W-1:0] lim;
  logic exp_en;
  logic [WORD_W-1:0] new_contrib;
  logic ovf;
  logic [IDX_W-1:0] slot;

  // scan pipeline
  logic [CNT_W-1:0] iss;
  logic a_vld;
  logic [IDX_W-1:0] a_idx;
  logic b_vld;
  logic [IDX_W-1:0] b_idx;
  logic b_valid;
  logic [END_W-1:0] b_end;
  logic [WORD_W-1:0] b_contrib;

  // scan results
  logic [ACC_W-1:0] acc;
  logic found_free;
  logic [IDX_W-1:0] free_slot;
  logic min_set;
  logic [END_W-1:0] min_end;
  logic [IDX_W-1:0] min_slot;
  logic [WORD_W-1:0] min_contrib;

  // store ports
  store_wr_t st_wr;
  logic [IDX_W-1:0] rd_addr;
  logic [TICK_W-1:0] rd_start;
  logic [WORD_W-1:0] rd_length;

  slwm_store u_store (
    .clk       (clk),
    .wr        (st_wr),
    .rd_addr   (rd_addr),
    .rd_start  (rd_start),
    .rd_length (rd_length)
  );

  // Contribution of one length to the window total under the current method.
  function automatic logic [WORD_W-1:0] contrib_of(
    input logic [METHOD_W-1:0] method,
    input logic [WORD_W-1:0] len,
    input logic [WORD_W-1:0] thr
  );
    logic [WORD_W:0] diff;
    logic [WORD_W-1:0] res;
    diff = {1'b0, len} - {1'b0, thr};
    case (method)
      METHOD_SUM:    res = len;
      METHOD_EXCESS: res = diff[WORD_W] ? '0 : diff[WORD_W-1:0];
      default:       res = '0;
    endcase
    return res;
  endfunction

  assign busy = (state != S_IDLE);
  wire accept = start && !busy;
  wire fast = duration < slow_threshold;

  // Stage A: end tick and contribution of the entry just read.
  wire [END_W-1:0] a_end = {1'b0, rd_start} + END_W'(rd_length);
  wire [WORD_W-1:0] a_contrib = contrib_of(check_method, rd_length, slow_threshold);

  // Stage B: expiry and bookkeeping for one entry.
  wire b_survive = b_valid && !(exp_en && (b_end <= lim));
  wire b_expire = b_valid && !b_survive;
  wire last_b = b_vld && (b_idx == IDX_W'(MAX_ENTRIES - 1));

  assign rd_addr = iss[IDX_W-1:0];

  // Bound on end ticks that expire: end + window_period <= now, i.e. end <= now - period.
  wire [END_W:0] lim_diff = {1'b0, now} - (END_W + 1)'(window_period);

  wire [ACC_W-1:0] total_max = ACC_W'({TOTAL_W{1'b1}});

  always_comb begin
    st_wr.en = (state == S_ADD);
    st_wr.addr = slot;
    st_wr.start_tick = it_start;
    st_wr.length = it_dur;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      check_method <= METHOD_RESET;
      window_period <= WINDOW_RESET;
      slow_threshold <= THRESHOLD_RESET;
      slow_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_CHECK_METHOD:   check_method <= wr_data[METHOD_W-1:0];
        REG_WINDOW_PERIOD:  window_period <= wr_data;
        REG_SLOW_THRESHOLD: slow_threshold <= wr_data;
        REG_SLOW_LIMIT:     slow_limit <= wr_data;
        default:            ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      valid <= '0;
      live_count <= '0;
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (fast) begin
              // fast access: report the entry count as it stands, with no total
              done <= 1'b1;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          a_vld <= 1'b0;
          b_vld <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          a_vld <= (iss != CNT_W'(MAX_ENTRIES));
          b_vld <= a_vld;
          if (b_vld && b_expire) begin
            valid[b_idx] <= 1'b0;
            live_count <= live_count - 1'b1;
          end
          if (last_b) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          state <= S_ADD;
        end
        S_ADD: begin
          valid[slot] <= 1'b1;
          if (!ovf) begin
            live_count <= live_count + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          it_start <= start_tick;
          it_dur <= duration;
          now <= {1'b0, start_tick} + END_W'(duration);
          if (fast) begin
            recorded <= 1'b0;
            disk_slow <= 1'b0;
            entry_count <= COUNT_OUT_W'(live_count);
            window_total <= '0;
            overflow <= 1'b0;
          end
        end
      end
      S_PREP: begin
        exp_en <= !lim_diff[END_W];
        lim <= lim_diff[END_W-1:0];
        new_contrib <= contrib_of(check_method, it_dur, slow_threshold);
        iss <= '0;
        acc <= '0;
        found_free <= 1'b0;
        min_set <= 1'b0;
      end
      S_SCAN: begin
        // advance the read address
        if (iss != CNT_W'(MAX_ENTRIES)) begin
          iss <= iss + 1'b1;
        end
        a_idx <= rd_addr;
        // stage A to stage B
        b_idx <= a_idx;
        b_valid <= valid[a_idx];
        b_end <= a_end;
        b_contrib <= a_contrib;
        // stage B: sum survivors, find first free slot and earliest end
        if (b_vld) begin
          if (b_survive) begin
            acc <= acc + ACC_W'(b_contrib);
            if (!min_set || (b_end < min_end)) begin
              min_set <= 1'b1;
              min_end <= b_end;
              min_slot <= b_idx;
              min_contrib <= b_contrib;
            end
          end else if (!found_free) begin
            found_free <= 1'b1;
            free_slot <= b_idx;
          end
        end
      end
      S_FIX: begin
        // pick the first free slot; if the window is full, drop the entry with the earliest end
        ovf <= !found_free;
        slot <= found_free ? free_slot : min_slot;
        if (!found_free) begin
          acc <= acc - ACC_W'(min_contrib);
        end
      end
      S_ADD: begin
        acc <= acc + ACC_W'(new_contrib);
      end
      S_DONE: begin
        recorded <= 1'b1;
        overflow <= ovf;
        entry_count <= COUNT_OUT_W'(live_count);
        case (check_method)
          METHOD_SUM, METHOD_EXCESS: begin
            disk_slow <= acc >= ACC_W'(slow_limit);
            window_total <= (acc > total_max) ? {TOTAL_W{1'b1}} : acc[TOTAL_W-1:0];
          end
          METHOD_COUNT: begin
            disk_slow <= WORD_W'(live_count) >= slow_limit;
            window_total <= '0;
          end
          default: begin
            disk_slow <= 1'b0;
            window_total <= '0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // assertions
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while a request is in flight");

  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted request produced neither a result nor busy");

  a_live_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == 32'(live_count))
    else $error("live count disagrees with valid entries");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (recorded && (entry_count == COUNT_OUT_W'(MAX_ENTRIES))))
    else $error("overflow reported with a window that is not full");

endmodule

`default_nettype wire
